@@ hw/rtl/sarc_pkg.sv @@
`timescale 1ns / 1ps
package sarc_pkg;
  localparam int MAX_SETS   = 2048;
  localparam int MAX_WAYS   = 8;
  localparam int BLOCK_BITS = 20;
  localparam int SET_W      = $clog2(MAX_SETS);
  localparam int WAY_W      = $clog2(MAX_WAYS);
  localparam int FILL_W     = $clog2(MAX_WAYS + 1);
  localparam int ROW_W      = MAX_WAYS * BLOCK_BITS;
  localparam int CNT_W      = 32;
  localparam int CLR_W      = SET_W + 1;

  // reciprocals for the set count, exact for a 12-bit block count
  localparam int RECIP_SH   = 24;
  localparam int RECIP_3    = ((1 << RECIP_SH) + 2) / 3;
  localparam int RECIP_5    = ((1 << RECIP_SH) + 4) / 5;
  localparam int RECIP_6    = ((1 << RECIP_SH) + 5) / 6;
  localparam int RECIP_7    = ((1 << RECIP_SH) + 6) / 7;

  localparam logic [0:0] REG_CACHE_BLOCKS = 1'b0;
  localparam logic [0:0] REG_WAYS_IN_USE  = 1'b1;

  typedef enum logic [2:0] {
    BK_CLEAR, BK_IDLE, BK_READ, BK_WAIT, BK_WRITE
  } bk_state_t;

  typedef enum logic [1:0] {
    FR_IDLE, FR_DIV, FR_PUSH
  } fr_state_t;

  // queue entry between classifier and set engine
  typedef struct packed {
    logic [BLOCK_BITS-1:0] blk;
    logic [SET_W-1:0]      set;
  } sarc_req_t;
endpackage

@@ hw/rtl/sarc_ram.sv @@
`timescale 1ns / 1ps
module sarc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/sarc_front.sv @@
`timescale 1ns / 1ps
module sarc_front import sarc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BLOCK_BITS-1:0] in_block_number,
  input  logic [SET_W:0]        eff_sets,
  output logic                  q_valid,
  input  logic                  q_ready,
  output sarc_req_t             q_data
);
  // restoring remainder, one bit a cycle
  fr_state_t                state_r, state_nxt;
  logic [BLOCK_BITS-1:0]    blk_r, blk_nxt;
  logic [SET_W+1:0]         rem_r, rem_nxt;
  logic [$clog2(BLOCK_BITS)-1:0] bit_r, bit_nxt;
  logic [SET_W+1:0]         shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    blk_r <= blk_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    blk_nxt   = blk_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    in_ready  = 1'b0;
    q_valid   = 1'b0;
    shifted   = {rem_r[SET_W:0], blk_r[bit_r]};
    case (state_r)
      FR_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          blk_nxt   = in_block_number;
          rem_nxt   = '0;
          bit_nxt   = ($clog2(BLOCK_BITS))'(BLOCK_BITS - 1);
          state_nxt = FR_DIV;
        end
      end
      FR_DIV: begin
        if (shifted >= {1'b0, eff_sets}) begin
          rem_nxt = shifted - {1'b0, eff_sets};
        end else begin
          rem_nxt = shifted;
        end
        if (bit_r == '0) begin
          state_nxt = FR_PUSH;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      FR_PUSH: begin
        q_valid = 1'b1;
        if (q_ready) begin
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  assign q_data.blk = blk_r;
  assign q_data.set = rem_r[SET_W-1:0];
endmodule

@@ hw/rtl/sarc_back.sv @@
`timescale 1ns / 1ps
module sarc_back import sarc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  sarc_req_t          q_data,
  input  logic [FILL_W-1:0]  eff_ways,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic [2:0]         out_found_rank,
  output logic [10:0]        out_set_index,
  output logic [31:0]        out_miss_count
);
  bk_state_t             state_r, state_nxt;
  sarc_req_t             req_r, req_nxt;
  logic [CLR_W-1:0]      clr_r, clr_nxt;
  logic [CNT_W-1:0]      miss_r, miss_nxt;
  logic                  ov_r, ov_nxt;
  logic                  hit_r, hit_nxt;
  logic [WAY_W-1:0]      rank_r, rank_nxt;
  logic [SET_W-1:0]      oset_r, oset_nxt;
  logic [ROW_W-1:0]      row_rd, row_wd;
  logic [FILL_W-1:0]     fill_rd, fill_wd, fill_c;
  logic                  we;
  logic [SET_W-1:0]      waddr;
  logic [SET_W-1:0]      raddr;
  logic                  found;
  logic [WAY_W-1:0]      frank;
  logic [BLOCK_BITS-1:0] ent [MAX_WAYS];
  logic [BLOCK_BITS-1:0] nent [MAX_WAYS];
  logic [WAY_W-1:0]      top;

  // hold the read on the set in hand; the queue may refill meanwhile
  assign raddr = (state_r == BK_IDLE) ? q_data.set : req_r.set;

  sarc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_rows (
    .clk(clk), .we(we && state_r == BK_WRITE), .waddr(waddr), .wdata(row_wd),
    .raddr(raddr), .rdata(row_rd));
  sarc_ram #(.WIDTH(FILL_W), .DEPTH(MAX_SETS)) u_fill (
    .clk(clk), .we(we), .waddr(waddr), .wdata(fill_wd),
    .raddr(raddr), .rdata(fill_rd));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
      clr_r   <= '0;
      miss_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      miss_r  <= miss_nxt;
      ov_r    <= ov_nxt;
    end
    req_r  <= req_nxt;
    hit_r  <= hit_nxt;
    rank_r <= rank_nxt;
    oset_r <= oset_nxt;
  end

  // hit search and row rebuild, eight narrow compares
  always_comb begin
    fill_c = (fill_rd > FILL_W'(MAX_WAYS)) ? FILL_W'(MAX_WAYS) : fill_rd;
    found  = 1'b0;
    frank  = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      ent[i] = row_rd[i*BLOCK_BITS +: BLOCK_BITS];
    end
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (FILL_W'(i) < fill_c && ent[i] == req_r.blk) begin
        found = 1'b1;
        frank = WAY_W'(i);
      end
    end
    top = found ? frank : WAY_W'(fill_c - 1'b1);
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (!found && fill_c < eff_ways) begin
        nent[i] = (FILL_W'(i) == fill_c) ? req_r.blk : ent[i];
      end else if (i == 0) begin
        nent[i] = req_r.blk;
      end else if (WAY_W'(i) <= top) begin
        nent[i] = ent[i-1];
      end else begin
        nent[i] = ent[i];
      end
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      row_wd[i*BLOCK_BITS +: BLOCK_BITS] = nent[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    clr_nxt   = clr_r;
    miss_nxt  = miss_r;
    ov_nxt    = ov_r;
    hit_nxt   = hit_r;
    rank_nxt  = rank_r;
    oset_nxt  = oset_r;
    q_ready   = 1'b0;
    we        = 1'b0;
    waddr     = req_r.set;
    fill_wd   = fill_rd;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      BK_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r[SET_W-1:0];
        fill_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_W'(MAX_SETS - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          req_nxt   = q_data;
          state_nxt = BK_WAIT;
        end
      end
      BK_WAIT: state_nxt = BK_WRITE;
      BK_WRITE: begin
        if (!ov_r || out_ready) begin
          we = 1'b1;
          if (!found && fill_c < eff_ways) begin
            fill_wd = fill_c + 1'b1;
          end else begin
            fill_wd = fill_rd;
          end
          if (!found && miss_r != '1) begin
            miss_nxt = miss_r + 1'b1;
          end
          hit_nxt   = found;
          rank_nxt  = found ? frank : '0;
          oset_nxt  = req_r.set;
          ov_nxt    = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      BK_READ: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign out_valid      = ov_r;
  assign out_hit        = hit_r;
  assign out_found_rank = 3'(rank_r);
  assign out_set_index  = 11'(oset_r);
  assign out_miss_count = miss_r;
endmodule

@@ hw/rtl/set_assoc_recency_cache_sim.sv @@
`timescale 1ns / 1ps
// Path from the accepting edge to out_valid: 20 remainder steps (one bit a
// cycle), the hand-over state, the queue register, then the wait and write
// states of the set engine before the result register loads.
// The bit-serial remainder unit sets throughput, taking a new block only once
// the last is queued; the set engine overlaps it. A stalled result holds it up.
// Reset: synchronous; a clearing pass over all 2048 sets zeroes the fill
// counts before the set engine takes its first item.
module set_assoc_recency_cache_sim import sarc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] in_block_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [2:0]  out_found_rank,
  output logic [10:0] out_set_index,
  output logic [31:0] out_miss_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  logic [11:0]       blocks_r;
  logic [3:0]        ways_r;
  logic [FILL_W-1:0] eff_ways;
  logic [SET_W:0]    eff_sets_r, eff_sets_nxt;
  logic              fv, fr, q_valid_r, bv, br;
  sarc_req_t         fd, q_data_r;
  logic [11:0]       quo;
  logic [35:0]       prod;

  assign cfg_ready = 1'b1;

  // set count: shifts for power-of-two ways, reciprocal multiply otherwise
  always_comb begin
    eff_ways = (ways_r == '0) ? FILL_W'(1)
             : (ways_r > 4'(MAX_WAYS)) ? FILL_W'(MAX_WAYS) : FILL_W'(ways_r);
    eff_sets_nxt = '0;
    prod = '0;
    case (eff_ways)
      FILL_W'(1): quo = blocks_r;
      FILL_W'(2): quo = blocks_r >> 1;
      FILL_W'(4): quo = blocks_r >> 2;
      FILL_W'(8): quo = blocks_r >> 3;
      FILL_W'(3): begin
        prod = 36'(blocks_r) * 36'(RECIP_3);
        quo  = prod[RECIP_SH +: 12];
      end
      FILL_W'(5): begin
        prod = 36'(blocks_r) * 36'(RECIP_5);
        quo  = prod[RECIP_SH +: 12];
      end
      FILL_W'(6): begin
        prod = 36'(blocks_r) * 36'(RECIP_6);
        quo  = prod[RECIP_SH +: 12];
      end
      FILL_W'(7): begin
        prod = 36'(blocks_r) * 36'(RECIP_7);
        quo  = prod[RECIP_SH +: 12];
      end
      default: quo = blocks_r;
    endcase
    if (quo == '0) begin
      eff_sets_nxt = (SET_W+1)'(1);
    end else if (quo > 12'(MAX_SETS)) begin
      eff_sets_nxt = (SET_W+1)'(MAX_SETS);
    end else begin
      eff_sets_nxt = quo[SET_W:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_r   <= 12'd256;
      ways_r     <= 4'd4;
      eff_sets_r <= (SET_W+1)'(64);
      q_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == REG_CACHE_BLOCKS) blocks_r <= cfg_data;
      if (cfg_valid && cfg_index == REG_WAYS_IN_USE) ways_r <= cfg_data[3:0];
      eff_sets_r <= eff_sets_nxt;
      if (fv && fr) q_valid_r <= 1'b1;
      else if (bv && br) q_valid_r <= 1'b0;
    end
    if (fv && fr) q_data_r <= fd;
  end

  assign fr = !q_valid_r;
  assign bv = q_valid_r;

  sarc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_block_number(in_block_number), .eff_sets(eff_sets_r),
    .q_valid(fv), .q_ready(fr), .q_data(fd));

  sarc_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(bv), .q_ready(br), .q_data(q_data_r),
    .eff_ways(eff_ways), .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_found_rank(out_found_rank),
    .out_set_index(out_set_index), .out_miss_count(out_miss_count));
endmodule

@@ hw/rtl/sarc_checker.sv @@
`timescale 1ns / 1ps
module sarc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [2:0]  out_found_rank,
  input logic [31:0] out_miss_count
);
  a_rank_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_found_rank == 3'd0) else $error("rank on miss");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_miss_count))
    else $error("result dropped");
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> out_miss_count >= $past(out_miss_count))
    else $error("miss count fell");
endmodule

bind set_assoc_recency_cache_sim sarc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_hit(out_hit), .out_found_rank(out_found_rank),
  .out_miss_count(out_miss_count));

@@ tb/sv/tb_set_assoc_recency_cache_sim.sv @@
`timescale 1ns / 1ps
module tb_set_assoc_recency_cache_sim;
  import sarc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int N_PHASES = 8;
  localparam int N_DIRECTED = 16;

  typedef struct {
    logic        hit;
    logic [2:0]  rank;
    logic [10:0] set;
    logic [31:0] misses;
  } access_result_t;

  typedef struct {
    logic [19:0] blk;
    bit          typed;
    logic        hit;
    logic [2:0]  rank;
    logic [10:0] set;
    logic [31:0] misses;
  } dir_row_t;

  typedef struct {
    logic [11:0] blocks;
    logic [3:0]  ways;
    int          send_idle;
    int          recv_stall;
  } phase_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [19:0] in_block_number;
  logic out_valid;
  logic out_ready;
  logic out_hit;
  logic [2:0] out_found_rank;
  logic [10:0] out_set_index;
  logic [31:0] out_miss_count;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [11:0] cfg_data;

  // predictor state
  logic [19:0] resident [MAX_SETS][MAX_WAYS];
  int          set_fill [MAX_SETS];
  logic [31:0] miss_total;
  logic [11:0] cache_blocks_q;
  logic [3:0]  ways_q;

  access_result_t pending_q[$];
  int errors;
  int items_sent;
  int results_seen;
  int hits_seen;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  set_assoc_recency_cache_sim uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_block_number(in_block_number),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_found_rank(out_found_rank), .out_set_index(out_set_index),
    .out_miss_count(out_miss_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int eff_ways();
    int w;
    w = ways_q;
    if (w == 0) w = 1;
    if (w > MAX_WAYS) w = MAX_WAYS;
    return w;
  endfunction

  function automatic int eff_sets();
    int s;
    s = cache_blocks_q / eff_ways();
    if (s == 0) s = 1;
    if (s > MAX_SETS) s = MAX_SETS;
    return s;
  endfunction

  function automatic access_result_t predict_access(logic [19:0] blk);
    access_result_t r;
    int s;
    int fill;
    int rank;
    bit found;
    s = blk % eff_sets();
    fill = set_fill[s];
    if (fill > MAX_WAYS) fill = MAX_WAYS;
    found = 0;
    rank = 0;
    for (int i = 0; i < fill; i++)
      if (!found && resident[s][i] == blk) begin
        found = 1;
        rank = i;
      end
    if (found) begin
      for (int i = rank; i > 0; i--) resident[s][i] = resident[s][i-1];
      resident[s][0] = blk;
    end else begin
      if (fill < eff_ways()) begin
        resident[s][fill] = blk;
        set_fill[s] = fill + 1;
      end else begin
        // full set (or over-full after shrinking ways): drop the back entry
        for (int i = fill - 1; i > 0; i--) resident[s][i] = resident[s][i-1];
        resident[s][0] = blk;
      end
      if (miss_total != 32'hFFFF_FFFF) miss_total = miss_total + 1;
    end
    r.hit = found;
    r.rank = found ? rank[2:0] : 3'd0;
    r.set = s[10:0];
    r.misses = miss_total;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", field, got, want,
             results_seen);
    errors++;
  endtask

  // receiver and checker
  always @(posedge clk) begin
    access_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = pending_q.pop_front();
        if (out_hit !== e.hit) report_mismatch("hit", out_hit, e.hit);
        if (out_found_rank !== e.rank) report_mismatch("found_rank", out_found_rank, e.rank);
        if (out_set_index !== e.set) report_mismatch("set_index", out_set_index, e.set);
        if (out_miss_count !== e.misses)
          report_mismatch("miss_count", out_miss_count, e.misses);
      end
      results_seen++;
      if (out_hit === 1'b1) hits_seen++;
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_access(logic [19:0] blk, bit typed, access_result_t want);
    access_result_t p;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_block_number <= blk;
    do @(posedge clk); while (!in_ready);
    p = predict_access(blk);
    if (typed) begin
      pending_q.push_back(want);
    end else begin
      pending_q.push_back(p);
    end
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CACHE_BLOCKS) cache_blocks_q = value;
    else ways_q = value[3:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  dir_row_t dir_rows [N_DIRECTED];
  phase_t   phases [N_PHASES];
  logic [19:0] pool [48];

  task automatic refill_pool(int k);
    // half the pool crowds a few sets so that hits and evictions are common
    if (k % 2 == 0)
      pool[k] = 20'($urandom_range(0, 9) * eff_sets() + $urandom_range(0, 2));
    else
      pool[k] = 20'($urandom_range(0, 20'hFFFFF));
  endtask

  initial begin
    access_result_t want;
    access_result_t none;
    logic [19:0] blk;
    dir_rows = '{
      '{20'd0,       1, 1'b0, 3'd0, 11'd0,  32'd1},
      '{20'd0,       1, 1'b1, 3'd0, 11'd0,  32'd1},
      '{20'd64,      1, 1'b0, 3'd0, 11'd0,  32'd2},
      '{20'd128,     1, 1'b0, 3'd0, 11'd0,  32'd3},
      '{20'd192,     1, 1'b0, 3'd0, 11'd0,  32'd4},
      '{20'd192,     1, 1'b1, 3'd3, 11'd0,  32'd4},
      '{20'd256,     1, 1'b0, 3'd0, 11'd0,  32'd5},
      '{20'd128,     1, 1'b0, 3'd0, 11'd0,  32'd6},
      '{20'hFFFFF,   1, 1'b0, 3'd0, 11'd63, 32'd7},
      '{20'hFFFFF,   1, 1'b1, 3'd0, 11'd63, 32'd7},
      '{20'd64,      1, 1'b0, 3'd0, 11'd0,  32'd8},
      '{20'd192,     1, 1'b1, 3'd3, 11'd0,  32'd8},
      '{20'h80000,   0, 1'b0, 3'd0, 11'd0,  32'd0},
      '{20'h55555,   0, 1'b0, 3'd0, 11'd0,  32'd0},
      '{20'hAAAAA,   0, 1'b0, 3'd0, 11'd0,  32'd0},
      '{20'h55555,   0, 1'b0, 3'd0, 11'd0,  32'd0}
    };
    // blocks, ways, sender idle %, receiver stall %
    phases = '{
      '{12'd256,  4'd4,  0,  0},
      '{12'd2048, 4'd1,  81, 0},
      '{12'd4095, 4'd15, 0,  81},
      '{12'd0,    4'd0,  27, 27},
      '{12'd12,   4'd8,  0,  0},
      '{12'd3,    4'd8,  27, 27},
      '{12'd100,  4'd2,  81, 0},
      '{12'd2047, 4'd7,  0,  81}
    };
    none = '{1'b0, 3'd0, 11'd0, 32'd0};
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_block_number = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    foreach (set_fill[s]) set_fill[s] = 0;
    miss_total = '0;
    cache_blocks_q = 12'd256;
    ways_q = 4'd4;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < N_DIRECTED; k++) begin
      want = '{dir_rows[k].hit, dir_rows[k].rank, dir_rows[k].set, dir_rows[k].misses};
      send_access(dir_rows[k].blk, dir_rows[k].typed, want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(REG_CACHE_BLOCKS, phases[ph].blocks);
        write_reg(REG_WAYS_IN_USE, phases[ph].ways);
      end
      send_idle_pct = phases[ph].send_idle;
      recv_stall_pct = phases[ph].recv_stall;
      for (int k = 0; k < 48; k++) refill_pool(k);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == 90) begin
          // hold off until the block has nothing outstanding
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_q.size() != 0) @(posedge clk);
        end
        if ($urandom_range(99) < 75) blk = pool[$urandom_range(0, 47)];
        else blk = 20'($urandom_range(0, 20'hFFFFF));
        if ($urandom_range(99) < 5) refill_pool($urandom_range(0, 47));
        send_access(blk, 0, none);
      end
    end

    drain();
    $display("ran %0d accesses over %0d geometries, %0d hits, %0d results checked",
             items_sent, N_PHASES, hits_seen, results_seen);
    $display("idling mixes covered: none, sender, receiver, both; %0d mismatches", errors);
    if (errors == 0 && pending_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/sarc_pkg.sv
hw/rtl/sarc_ram.sv
hw/rtl/sarc_front.sv
hw/rtl/sarc_back.sv
hw/rtl/set_assoc_recency_cache_sim.sv
hw/rtl/sarc_checker.sv
tb/sv/tb_set_assoc_recency_cache_sim.sv
